// ----- rtl/core/psmx_pkg.sv -----
// Shared types, codes and the volume table of the rhythm sample mixer.
package psmx_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_SMP,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CFG_STEP   = 2'd0,
        CFG_MASTER = 2'd1,
        CFG_VATT   = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] step;
        logic signed [8:0]  master_att;
        logic        [47:0] voice_att;
    } cfg_t;

    localparam logic [7:0] REG_KEY    = 8'h10;
    localparam logic [7:0] REG_TL     = 8'h11;
    localparam logic [7:0] REG_PAN_LO = 8'h18;
    localparam logic [7:0] REG_PAN_HI = 8'h1D;

    localparam int KEY_LIMIT  = 6;
    localparam int ROM_DEPTH  = 159;
    localparam int ATT_MIN    = -31;
    localparam int ATT_MAX    = 127;
    localparam int VOL_SHIFT  = 12;

    localparam logic [15:0] STEP_RESET = 16'd1024;

    typedef logic [15:0] vol_rom_t [ROM_DEPTH];

    // 2^(b/8) scaled by 10^12
    localparam logic [63:0] ROOT_EIGHTHS [8] = '{
        64'd1000000000000, 64'd1090507732665, 64'd1189207115002, 64'd1296839554651,
        64'd1414213562373, 64'd1542210825407, 64'd1681792830507, 64'd1834008086409
    };

    function automatic vol_rom_t build_vol_rom();
        vol_rom_t    rom;
        logic [63:0] v;
        int          e;
        for (int d = 0; d < ROM_DEPTH; d++)
        begin
            e = ROM_DEPTH - d;
            v = (ROOT_EIGHTHS[e & 7] << (e >> 3)) / 64'd1000000000000;
            rom[d] = 16'((v - 64'd1) >> 4);
        end
        return rom;
    endfunction

    localparam vol_rom_t VOL_ROM = build_vol_rom();

endpackage

// ----- rtl/core/psmx_if.sv -----
// Request channels of the mixer: input commands and mixed stereo results.
interface psmx_in_if;
    import psmx_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [7:0]         reg_addr;
    logic [7:0]         reg_value;
    logic [2:0]         voice_index;
    logic [13:0]        load_address;
    logic signed [15:0] load_sample;
    logic               load_last;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;

    modport source (output valid, cmd, reg_addr, reg_value, voice_index, load_address,
                    load_sample, load_last, mix_left, mix_right, input ready);
    modport sink (input valid, cmd, reg_addr, reg_value, voice_index, load_address,
                  load_sample, load_last, mix_left, mix_right, output ready);
endinterface

interface psmx_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink (input valid, out_left, out_right, output ready);
endinterface

// ----- rtl/core/psmx_cfg.sv -----
// APB configuration registers: playback step, master and per-voice attenuation.
module psmx_cfg
    import psmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[4:3]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step       <= STEP_RESET;
            cfg_reg.master_att <= '0;
            cfg_reg.voice_att  <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                CFG_STEP:   cfg_reg.step       <= pwdata[15:0];
                CFG_MASTER: cfg_reg.master_att <= pwdata[8:0];
                CFG_VATT:   cfg_reg.voice_att  <= pwdata[47:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            CFG_STEP:   prdata = {48'd0, cfg_reg.step};
            CFG_MASTER: prdata = {55'd0, cfg_reg.master_att};
            CFG_VATT:   prdata = {16'd0, cfg_reg.voice_att};
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/psmx_smem.sv -----
// Sample memory: one write port, one registered read port.
module psmx_smem
    import psmx_pkg::*;
#(
    parameter int DEPTH = 98304,
    parameter int AW    = 17
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic signed [15:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic signed [15:0] rdata
);

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/psmx_engine.sv -----
// Voice sequencer: register decode, position memory and the per-voice mix pass.
module psmx_engine
    import psmx_pkg::*;
#(
    parameter int VOICES        = 6,
    parameter int VOICE_WORDS   = 16384,
    parameter int FRACTION_BITS = 10,
    parameter int AW            = 17
)
(
    input  logic               clk,
    input  logic               rst_n,
    psmx_in_if.sink            in_ch,
    psmx_out_if.source         out_ch,
    input  cfg_t               cfg,
    output logic               smem_we,
    output logic [AW-1:0]      smem_waddr,
    output logic signed [15:0] smem_wdata,
    output logic               smem_re,
    output logic [AW-1:0]      smem_raddr,
    input  logic signed [15:0] smem_rdata
);

    localparam int IDX_W  = (VOICE_WORDS > 1) ? $clog2(VOICE_WORDS) : 1;
    localparam int BASE_W = IDX_W + FRACTION_BITS;
    localparam int POS_W  = ((BASE_W > 16) ? BASE_W : 16) + 1;
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;

    state_t state_reg, state_next;

    logic [VW-1:0]      vcnt_reg;
    logic signed [15:0] left_reg, right_reg;
    logic [VOICES-1:0]  key_reg;
    logic [5:0]         tl_reg;
    logic [1:0]         pan_reg [VOICES];
    logic [4:0]         lvl_reg [VOICES];
    logic [POS_W-1:0]   len_reg [VOICES];
    logic               loaded_reg;
    logic [VOICES-1:0]  pos_vld_reg;
    logic [VOICES-1:0]  pos_zero_reg;

    logic [POS_W-1:0]   pos_mem [VOICES];
    logic [POS_W-1:0]   pos_rd_reg;

    logic               act_reg;
    logic [1:0]         pan_cur_reg;
    logic [15:0]        vol_reg;
    logic signed [32:0] prod_reg;

    logic               out_vld_reg;
    logic signed [15:0] out_l_reg, out_r_reg;

    logic               fire, mute, last_voice, slot_free, load_ok;
    cmd_t               cmd;
    logic [POS_W-1:0]   pos_eff;
    logic               active;
    logic signed [7:0]  vatt;
    logic signed [10:0] att;
    logic [7:0]         rom_idx;
    logic signed [20:0] term;
    logic signed [21:0] sum_l, sum_r;
    logic signed [15:0] sat_l, sat_r;

    assign cmd        = cmd_t'(in_ch.cmd);
    assign fire       = in_ch.valid && in_ch.ready;
    assign mute       = (key_reg == '0) || !loaded_reg
                        || (!cfg.master_att[8] && cfg.master_att[7]);
    assign last_voice = (vcnt_reg == VW'(VOICES - 1));
    assign slot_free  = !out_vld_reg || out_ch.ready;
    assign load_ok    = (32'(in_ch.voice_index) < VOICES)
                        && (32'(in_ch.load_address) < VOICE_WORDS);

    // a restarted voice reads as zero, one never written back as not playing
    assign pos_eff = pos_zero_reg[vcnt_reg] ? '0
                   : (pos_vld_reg[vcnt_reg] ? pos_rd_reg : '1);
    assign active  = key_reg[vcnt_reg] && (pos_eff < len_reg[vcnt_reg]);

    assign vatt = (32'(vcnt_reg) < KEY_LIMIT) ? cfg.voice_att[{vcnt_reg, 3'b000} +: 8] : 8'sd0;
    assign att  = $signed({5'd0, tl_reg}) + 11'(cfg.master_att)
                + $signed({6'd0, lvl_reg[vcnt_reg]}) + 11'(vatt);

    always_comb
    begin
        if (att < 11'(ATT_MIN))
        begin
            rom_idx = 8'd0;
        end
        else if (att > 11'(ATT_MAX))
        begin
            rom_idx = 8'(ATT_MAX - ATT_MIN);
        end
        else
        begin
            rom_idx = 8'(att - 11'(ATT_MIN));
        end
    end

    assign term  = prod_reg[32:VOL_SHIFT];
    assign sum_l = 22'(left_reg) + 22'(term);
    assign sum_r = 22'(right_reg) + 22'(term);

    always_comb
    begin
        if (sum_l < -22'sd32768)     sat_l = -16'sd32768;
        else if (sum_l > 22'sd32767) sat_l = 16'sd32767;
        else                         sat_l = sum_l[15:0];
        if (sum_r < -22'sd32768)     sat_r = -16'sd32768;
        else if (sum_r > 22'sd32767) sat_r = 16'sd32767;
        else                         sat_r = sum_r[15:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire && cmd == CMD_TICK)
                begin
                    state_next = mute ? ST_DONE : ST_POS;
                end
            end
            ST_POS:  state_next = ST_SMP;
            ST_SMP:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = last_voice ? ST_DONE : ST_POS;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        smem_we     = fire && (cmd == CMD_LOAD) && load_ok;
        smem_waddr  = AW'(in_ch.voice_index * VOICE_WORDS) + AW'(in_ch.load_address);
        smem_wdata  = in_ch.load_sample;
        smem_re     = (state_reg == ST_SMP) && active;
        smem_raddr  = AW'(vcnt_reg * VOICE_WORDS) + AW'(IDX_W'(pos_eff >> FRACTION_BITS));
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.out_left  = out_l_reg;
    assign out_ch.out_right = out_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vcnt_reg     <= '0;
            key_reg      <= '0;
            tl_reg       <= '0;
            loaded_reg   <= 1'b0;
            pos_vld_reg  <= '0;
            pos_zero_reg <= '0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                pan_reg[i] <= '0;
                lvl_reg[i] <= '0;
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (fire && cmd == CMD_WRITE)
            begin
                if (in_ch.reg_addr == REG_KEY)
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        if (!in_ch.reg_value[7])
                        begin
                            if (in_ch.reg_value[i])
                            begin
                                pos_zero_reg[i] <= 1'b1;
                                if (i < KEY_LIMIT)
                                begin
                                    key_reg[i] <= 1'b1;
                                end
                            end
                        end
                        else if (in_ch.reg_value[i] || i >= KEY_LIMIT)
                        begin
                            key_reg[i] <= 1'b0;
                        end
                    end
                end
                else if (in_ch.reg_addr == REG_TL)
                begin
                    tl_reg <= ~in_ch.reg_value[5:0];
                end
                else if (in_ch.reg_addr >= REG_PAN_LO && in_ch.reg_addr <= REG_PAN_HI)
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        if (in_ch.reg_addr[2:0] == 3'(i))
                        begin
                            pan_reg[i] <= in_ch.reg_value[7:6];
                            lvl_reg[i] <= ~in_ch.reg_value[4:0];
                        end
                    end
                end
            end

            if (smem_we)
            begin
                loaded_reg <= 1'b1;
                if (in_ch.load_last)
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        if (in_ch.voice_index == 3'(i))
                        begin
                            len_reg[i]      <= POS_W'({1'b0, in_ch.load_address} + 15'd1)
                                               << FRACTION_BITS;
                            pos_zero_reg[i] <= 1'b1;
                        end
                    end
                end
            end

            if (fire && cmd == CMD_TICK)
            begin
                vcnt_reg <= '0;
            end
            else if (state_reg == ST_ACC && !last_voice)
            begin
                vcnt_reg <= vcnt_reg + VW'(1);
            end

            if (state_reg == ST_SMP && active)
            begin
                pos_vld_reg[vcnt_reg]  <= 1'b1;
                pos_zero_reg[vcnt_reg] <= 1'b0;
            end

            // hold the result until the sink takes it
            if (state_reg == ST_DONE && slot_free)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // position memory and mix datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POS)
        begin
            pos_rd_reg <= pos_mem[vcnt_reg];
        end
        if (state_reg == ST_SMP && active)
        begin
            pos_mem[vcnt_reg] <= pos_eff + POS_W'(cfg.step);
        end
        if (state_reg == ST_SMP)
        begin
            act_reg     <= active;
            pan_cur_reg <= pan_reg[vcnt_reg];
            vol_reg     <= VOL_ROM[rom_idx];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= smem_rdata * $signed({1'b0, vol_reg});
        end
        if (fire && cmd == CMD_TICK)
        begin
            left_reg  <= in_ch.mix_left;
            right_reg <= in_ch.mix_right;
        end
        else if (state_reg == ST_ACC && act_reg)
        begin
            if (pan_cur_reg[1]) left_reg  <= sat_l;
            if (pan_cur_reg[0]) right_reg <= sat_r;
        end
        if (state_reg == ST_DONE && slot_free)
        begin
            out_l_reg <= left_reg;
            out_r_reg <= right_reg;
        end
    end

endmodule

// ----- rtl/core/six_voice_rhythm_sample_mixer_top.sv -----
// Top level of the six-voice rhythm sample mixer.
// Register writes and sample loads leave the sequencer idle; the next request follows at once.
// A mix tick walks the voices one at a time, each through position read, sample read,
// multiply and accumulate; a muted tick skips the voice pass and goes straight to its result.
// Reset clears control, level and position state; the sample memory is undefined until loaded.
module six_voice_rhythm_sample_mixer_top
    import psmx_pkg::*;
#(
    parameter int VOICES        = 6,
    parameter int VOICE_WORDS   = 16384,
    parameter int FRACTION_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    psmx_in_if.sink     in_ch,
    psmx_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int DEPTH = VOICES * VOICE_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t               cfg;
    logic               smem_we, smem_re;
    logic [AW-1:0]      smem_waddr, smem_raddr;
    logic signed [15:0] smem_wdata, smem_rdata;

    psmx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psmx_smem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_smem (
        .clk   (clk),
        .we    (smem_we),
        .waddr (smem_waddr),
        .wdata (smem_wdata),
        .re    (smem_re),
        .raddr (smem_raddr),
        .rdata (smem_rdata)
    );

    psmx_engine #(
        .VOICES        (VOICES),
        .VOICE_WORDS   (VOICE_WORDS),
        .FRACTION_BITS (FRACTION_BITS),
        .AW            (AW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg),
        .smem_we    (smem_we),
        .smem_waddr (smem_waddr),
        .smem_wdata (smem_wdata),
        .smem_re    (smem_re),
        .smem_raddr (smem_raddr),
        .smem_rdata (smem_rdata)
    );

    // a tick request occupies the sequencer
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_TICK) |=> !in_ch.ready)
        else $error("ready stayed high after a mix tick request");

    // requests other than a tick finish in their own cycle
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.cmd != CMD_TICK) |=> in_ch.ready)
        else $error("sequencer left idle on a non-tick request");

    // a result only appears at the end of a tick pass
    a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(!in_ch.ready))
        else $error("result raised without a tick pass");

endmodule

// ----- tb/sv/psmx_mix_checker.sv -----
// Mix predictor and result comparison for the six-voice rhythm sample mixer.
`timescale 1ns / 1ps
module psmx_mix_checker
    import psmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    psmx_in_if          in_mon,
    psmx_out_if         out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } mix_pair_t;

    // 2^(b/8) scaled by 10^12
    localparam longint unsigned GAIN_ROOTS [8] = '{
        64'd1000000000000, 64'd1090507732665, 64'd1189207115002, 64'd1296839554651,
        64'd1414213562373, 64'd1542210825407, 64'd1681792830507, 64'd1834008086409
    };

    mix_pair_t          expected_mix [$];
    logic signed [15:0] voice_mem [6][16384];
    longint             play_len [6];
    longint             play_pos [6];
    logic [1:0]         pan [6];
    int                 voice_lvl [6];
    logic [5:0]         keys;
    int                 total_lvl;
    bit                 any_loaded;
    int                 gain [159];
    int                 step;
    int                 master_att;
    logic [47:0]        voice_att;

    function automatic void build_gain();
        int              e;
        longint unsigned v;
        for (int d = -31; d <= 127; d++)
        begin
            e = 128 - d;
            v = (GAIN_ROOTS[e & 7] << (e >> 3)) / 64'd1000000000000;
            gain[d + 31] = int'((v - 1) >> 4);
        end
    endfunction

    function automatic logic signed [15:0] sat_add(int acc, longint term);
        longint s;
        s = longint'(acc) + term;
        if (s < -32768)
            return -16'sd32768;
        if (s > 32767)
            return 16'sd32767;
        return 16'(s);
    endfunction

    task automatic apply_reg(logic [7:0] addr, logic [7:0] value);
        int v;
        if (addr == REG_KEY)
        begin
            if (!value[7])
            begin
                keys = keys | value[5:0];
                for (int i = 0; i < 6; i++)
                    if (value[i])
                        play_pos[i] = 0;
            end
            else
                keys = keys & ~value[5:0];
        end
        else if (addr == REG_TL)
            total_lvl = int'(~value[5:0]) & 6'h3F;
        else if (addr >= REG_PAN_LO && addr <= REG_PAN_HI)
        begin
            v = int'(addr[2:0]);
            pan[v] = value[7:6];
            voice_lvl[v] = int'(~value[4:0]) & 5'h1F;
        end
    endtask

    task automatic predict_mix(logic signed [15:0] in_l, logic signed [15:0] in_r);
        mix_pair_t r;
        int        att;
        int        va;
        longint    term;
        r.left = in_l;
        r.right = in_r;
        if (keys != 0 && any_loaded && master_att < 128)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (!keys[i] || play_pos[i] >= play_len[i])
                    continue;
                va = $signed(voice_att[8*i +: 8]);
                att = total_lvl + master_att + voice_lvl[i] + va;
                if (att < -31)
                    att = -31;
                if (att > 127)
                    att = 127;
                term = (longint'(voice_mem[i][play_pos[i] >> 10]) * gain[att + 31]) >>> 12;
                if (pan[i][1])
                    r.left = sat_add(r.left, term);
                if (pan[i][0])
                    r.right = sat_add(r.right, term);
                play_pos[i] = play_pos[i] + step;
            end
        end
        expected_mix.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_mix.delete();
            for (int i = 0; i < 6; i++)
            begin
                play_len[i] = 0;
                play_pos[i] = (64'd1 << 25) - 1;
                pan[i] = 2'b00;
                voice_lvl[i] = 0;
            end
            keys = '0;
            total_lvl = 0;
            any_loaded = 0;
            step = 1024;
            master_att = 0;
            voice_att = '0;
            build_gain();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_idx_t'(paddr[4:3]))
                    CFG_STEP:   step = int'(pwdata[15:0]);
                    CFG_MASTER: master_att = $signed(pwdata[8:0]);
                    CFG_VATT:   voice_att = pwdata[47:0];
                    default:    ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_mix.size() == 0)
                begin
                    $error("unexpected mix result: left %0d right %0d",
                           out_mon.out_left, out_mon.out_right);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    mix_pair_t e;
                    e = expected_mix.pop_front();
                    if (e.left !== out_mon.out_left)
                        $error("out_left: expected %0d, actual %0d", e.left, out_mon.out_left);
                    if (e.right !== out_mon.out_right)
                        $error("out_right: expected %0d, actual %0d",
                               e.right, out_mon.out_right);
                    if (e.left !== out_mon.out_left || e.right !== out_mon.out_right)
                        mismatches <= mismatches + 1;
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                case (cmd_t'(in_mon.cmd))
                    CMD_WRITE: apply_reg(in_mon.reg_addr, in_mon.reg_value);
                    CMD_LOAD:
                    begin
                        if (in_mon.voice_index < 6)
                        begin
                            voice_mem[in_mon.voice_index][in_mon.load_address] =
                                in_mon.load_sample;
                            any_loaded = 1;
                            if (in_mon.load_last)
                            begin
                                play_len[in_mon.voice_index] =
                                    longint'(in_mon.load_address + 1) << 10;
                                play_pos[in_mon.voice_index] = 0;
                            end
                        end
                    end
                    CMD_TICK: predict_mix(in_mon.mix_left, in_mon.mix_right);
                    default:  ;
                endcase
            end
            outstanding <= expected_mix.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Stimulus, handshake pacing and verdict for the six-voice rhythm sample mixer.
`timescale 1ns / 1ps
module testbench;
    import psmx_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_GOAL   = 1350;

    typedef struct {
        cmd_t               cmd;
        logic [7:0]         reg_addr;
        logic [7:0]         reg_value;
        logic [2:0]         voice_index;
        logic [13:0]        load_address;
        logic signed [15:0] load_sample;
        logic               load_last;
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
    } req_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          cycles;
    int          sent;
    int          idle_pct;
    int          stall_pct;
    int          hold_len;
    bit          word_written [6][16384];
    int          prefix [6];

    psmx_in_if  in_ch ();
    psmx_out_if out_ch ();

    six_voice_rhythm_sample_mixer_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    psmx_mix_checker u_mix_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver pacing; a pending hold wins over random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_len > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_len <= hold_len - 1;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic signed [15:0] rand_s16();
        case ($urandom_range(7))
            0:       return 16'sd32767;
            1:       return -16'sd32768;
            2:       return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(req_t r);
        int g;
        g = 0;
        while (g < 40 && $urandom_range(99) < idle_pct)
            g++;
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= r.cmd;
        in_ch.reg_addr <= r.reg_addr;
        in_ch.reg_value <= r.reg_value;
        in_ch.voice_index <= r.voice_index;
        in_ch.load_address <= r.load_address;
        in_ch.load_sample <= r.load_sample;
        in_ch.load_last <= r.load_last;
        in_ch.mix_left <= r.mix_left;
        in_ch.mix_right <= r.mix_right;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // random filler in the fields a command does not use
    function automatic req_t junk_req(cmd_t c);
        req_t r;
        r.cmd = c;
        r.reg_addr = 8'($urandom);
        r.reg_value = 8'($urandom);
        r.voice_index = 3'($urandom);
        r.load_address = 14'($urandom);
        r.load_sample = 16'($urandom);
        r.load_last = 1'($urandom);
        r.mix_left = 16'($urandom);
        r.mix_right = 16'($urandom);
        return r;
    endfunction

    task automatic send_write(logic [7:0] addr, logic [7:0] value);
        req_t r;
        r = junk_req(CMD_WRITE);
        r.reg_addr = addr;
        r.reg_value = value;
        send(r);
    endtask

    // last is dropped unless every word up to the address has been written
    task automatic send_load(logic [2:0] v, logic [13:0] a, logic signed [15:0] s, bit last);
        req_t r;
        r = junk_req(CMD_LOAD);
        r.voice_index = v;
        r.load_address = a;
        r.load_sample = s;
        if (v < 6)
        begin
            word_written[v][a] = 1'b1;
            while (prefix[v] < 16384 && word_written[v][prefix[v]])
                prefix[v]++;
            if (a >= prefix[v])
                last = 1'b0;
        end
        r.load_last = last;
        send(r);
    endtask

    task automatic send_tick(logic signed [15:0] l, logic signed [15:0] rr);
        req_t r;
        r = junk_req(CMD_TICK);
        r.mix_left = l;
        r.mix_right = rr;
        send(r);
    endtask

    task automatic send_clip(logic [2:0] v, int n);
        for (int a = 0; a < n; a++)
            send_load(v, 14'(a), rand_s16(), a == n - 1);
    endtask

    // drop valid, then let the block drain before touching registers
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic cfg_all(logic [15:0] stp, int master, logic [47:0] vatt);
        cfg_write(CFG_STEP, {48'd0, stp});
        cfg_write(CFG_MASTER, {55'd0, 9'(master)});
        cfg_write(CFG_VATT, {16'd0, vatt});
    endtask

    initial
    begin
        int         seg;
        int         n;
        logic [2:0] v;
        rst_n = 1'b0;
        cycles = 0;
        sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_len = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_NONE;
        in_ch.reg_addr = '0;
        in_ch.reg_value = '0;
        in_ch.voice_index = '0;
        in_ch.load_address = '0;
        in_ch.load_sample = '0;
        in_ch.load_last = 1'b0;
        in_ch.mix_left = '0;
        in_ch.mix_right = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 6; i++)
            prefix[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: mute before any load, extremes, ignored commands
        cfg_all(16'd1024, 0, 48'd0);
        send_tick(-16'sd32768, 16'sd32767);
        send_write(REG_KEY, 8'h01);
        send_tick(16'sd100, -16'sd100);
        send_load(3'd0, 14'd0, 16'sd32767, 1'b0);
        send_load(3'd0, 14'd1, -16'sd32768, 1'b0);
        send_load(3'd0, 14'd2, -16'sd1, 1'b1);
        send_load(3'd6, 14'd5, 16'sd1234, 1'b1);
        send_load(3'd7, 14'h3FFF, -16'sd5, 1'b1);
        send_write(REG_TL, 8'h3F);
        send_write(8'h18, 8'hFF);
        send_write(8'h12, 8'h55);
        send_write(8'h1E, 8'hC0);
        send_write(REG_KEY, 8'h01);
        send_tick(16'sd32767, 16'sd32767);
        send_tick(-16'sd32768, -16'sd32768);
        send_tick(16'sd0, 16'sd0);
        begin
            req_t r;
            r = junk_req(CMD_NONE);
            send(r);
        end
        send_write(REG_KEY, 8'h3F);
        send_write(8'h1D, 8'h80);
        send_write(8'h19, 8'h40);
        send_tick(16'sd7, -16'sd7);
        send_write(REG_KEY, 8'hBF);
        send_tick(16'sd1, 16'sd2);

        seg = 0;
        while (sent < ITEM_GOAL)
        begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (seg % 5 == 4)
            begin
                settle();
                case ((seg / 5) % 5)
                    0: cfg_all(16'hFFFF, -13, 48'h808080808080);
                    1: cfg_all(16'd0, 128, 48'h7F7F7F7F7F7F);
                    2: cfg_all(16'd1024, 0, {$urandom, 16'($urandom)});
                    3: cfg_all(16'($urandom_range(1, 4096)), $urandom_range(0, 140) - 13,
                               {$urandom, 16'($urandom)});
                    default: cfg_all(16'd512, $urandom_range(0, 33) - 13, 48'd0);
                endcase
            end
            v = 3'($urandom_range(5));
            n = ($urandom_range(7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
            send_clip(v, n);
            if ($urandom_range(1))
                send_write(8'(REG_PAN_LO + $urandom_range(5)), 8'($urandom));
            if ($urandom_range(3) == 0)
                send_write(REG_TL, 8'($urandom));
            send_write(REG_KEY, {1'b0, 1'($urandom), 6'($urandom) | (6'd1 << v)});
            if (seg == 7)
            begin
                // long receiver hold-off so the block backs up into its input
                hold_len = 300;
                idle_pct = 0;
                repeat (12) send_tick(rand_s16(), rand_s16());
            end
            else
                repeat ($urandom_range(2, 10)) send_tick(rand_s16(), rand_s16());
            if ($urandom_range(9) < 3)
            begin
                case ($urandom_range(3))
                    0: send_write(8'($urandom), 8'($urandom));
                    1:
                    begin
                        req_t r;
                        r = junk_req(CMD_NONE);
                        send(r);
                    end
                    2: send_load(3'($urandom), 14'($urandom), 16'($urandom), 1'($urandom));
                    default: send_write(REG_KEY, {1'b1, 7'($urandom)});
                endcase
            end
            if (seg == 9)
            begin
                // sender pause until the block has drained
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            seg++;
        end

        in_ch.valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
